/* sv/lru_replacement_list_top_defines.svh */
// Assertion macros shared by the LRU replacement list RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef LRU_REPLACEMENT_LIST_TOP_DEFINES_SVH
`define LRU_REPLACEMENT_LIST_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// clocked check, masked while reset is high
`define LRU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// clocked check that also holds during reset
`define LRU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LRU_ASSERT(label, clk, rst, prop, msg)
`define LRU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* sv/lru_pkg.sv */
// Package for the LRU replacement list: default sizes, cell control struct
// and controller state encoding. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lru_pkg;
   localparam int DEF_MAX_ENTRIES = 64;
   localparam int DEF_ID_WIDTH    = 16;
   localparam int CAP_W           = 7;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // request codes
   localparam logic REQ_TOUCH  = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // per-cell control: occupancy, shift from upper neighbor, load new id
   typedef struct packed {
      logic live;
      logic shift;
      logic load;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;
endpackage
`default_nettype wire

/* sv/lru_cell.sv */
// One slot of the recency chain: holds an id, compares it against the probe
// and takes its upper neighbor's id on a shift. Depends on lru_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lru_cell
   import lru_pkg::*;
#(
   parameter int ID_WIDTH = DEF_ID_WIDTH
) (
   input  wire logic                clock,
   input  wire cell_ctl_type        ctl,
   input  wire logic [ID_WIDTH-1:0] probe_id,
   input  wire logic [ID_WIDTH-1:0] load_id,
   input  wire logic [ID_WIDTH-1:0] upper_id,
   output logic      [ID_WIDTH-1:0] id_out,
   output logic                     match
);
   logic [ID_WIDTH-1:0] id_ff;
   logic [ID_WIDTH-1:0] id_in;

   // next id: new entry, neighbor shift, or hold
   always_comb begin
      if (ctl.load) begin
         id_in = load_id;
      end else if (ctl.shift) begin
         id_in = upper_id;
      end else begin
         id_in = id_ff;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id_out = id_ff;
   assign match  = ctl.live && (id_ff == probe_id);
endmodule
`default_nettype wire

/* sv/lru_replacement_list_top.sv */
// LRU replacement list: an accepted beat is compared across all cells and the
// match registered; the update state then shifts/loads the cell row and
// registers the result beat once the output slot is free. A new request is
// taken only in the idle state, so a held result adds stall.
// Reset (synchronous) clears the entry count and sets capacity to 64; the
// id cells are not cleared and are read only below the entry count.
// Depends on lru_pkg, lru_cell and lru_replacement_list_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_replacement_list_top_defines.svh"
module lru_replacement_list_top
   import lru_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int ID_WIDTH    = DEF_ID_WIDTH,
   localparam int CNT_W      = $clog2(MAX_ENTRIES + 1),
   localparam int IDX_W      = $clog2(MAX_ENTRIES)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // configuration
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CAP_W-1:0]    csr_active_capacity,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_type,
   input  wire logic [ID_WIDTH-1:0] req_page_id,
   // result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_hit,
   output logic                     rsp_evicted_valid,
   output logic      [ID_WIDTH-1:0] rsp_evicted_id,
   output logic                     rsp_oldest_valid,
   output logic      [ID_WIDTH-1:0] rsp_oldest_id,
   output logic      [CNT_W-1:0]    rsp_entry_count
);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CAP_W-1:0]     cap_ff;
   logic                 req_type_ff;
   logic [ID_WIDTH-1:0]  page_id_ff;
   logic [MAX_ENTRIES-1:0] match_ff;
   logic [MAX_ENTRIES-1:0] match;
   logic                 rsp_valid_ff;
   logic                 hit_ff, ev_valid_ff;
   logic [ID_WIDTH-1:0]  ev_id_ff, oldest_id_ff;
   logic                 oldest_valid_ff;
   logic [CNT_W-1:0]     rsp_count_ff;

   logic [ID_WIDTH-1:0]  cell_id [MAX_ENTRIES];
   logic [ID_WIDTH-1:0]  upper_id [MAX_ENTRIES];
   cell_ctl_type         cell_ctl [MAX_ENTRIES];

   logic                 req_fire, update_fire;
   logic                 touch, hit, evict, unlink, append;
   logic [IDX_W-1:0]     hit_pos, upos;
   logic [CNT_W-1:0]     count_mid;
   logic [CMP_W-1:0]     cap_wide, max_wide, cap_eff;
   logic [ID_WIDTH-1:0]  oldest_next;

   // handshakes
   assign csr_ready   = 1'b1;
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign update_fire = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   // effective capacity, clamped to 1..MAX_ENTRIES
   always_comb begin
      cap_wide = CMP_W'(cap_ff);
      max_wide = CMP_W'(MAX_ENTRIES);
      if (cap_wide == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_wide > max_wide) begin
         cap_eff = max_wide;
      end else begin
         cap_eff = cap_wide;
      end
   end

   // position of the matching cell; ids are unique so at most one cell matches
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_pos = hit_pos | (match_ff[i] ? IDX_W'(i) : '0);
      end
   end

   // update decision
   assign touch     = (req_type_ff == REQ_TOUCH);
   assign hit       = |match_ff;
   assign evict     = touch && !hit && (count_ff != '0) && (CMP_W'(count_ff) >= cap_eff);
   assign unlink    = hit || evict;
   assign upos      = hit ? hit_pos : '0;
   assign count_mid = count_ff - CNT_W'(unlink);
   assign append    = touch && (count_mid < CNT_W'(MAX_ENTRIES));
   assign count_in  = update_fire ? (count_mid + CNT_W'(append)) : count_ff;

   // cell row
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      if (i + 1 < MAX_ENTRIES) begin : g_up
         assign upper_id[i] = cell_id[i + 1];
      end else begin : g_top
         assign upper_id[i] = '0;
      end

      always_comb begin
         cell_ctl[i].live  = CNT_W'(i) < count_ff;
         cell_ctl[i].shift = update_fire && unlink && (IDX_W'(i) >= upos)
                             && (CNT_W'(i + 1) < count_ff);
         cell_ctl[i].load  = update_fire && append && (CNT_W'(i) == count_mid);
      end

      lru_cell #(
         .ID_WIDTH (ID_WIDTH)
      ) u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[i]),
         .probe_id (req_page_id),
         .load_id  (page_id_ff),
         .upper_id (upper_id[i]),
         .id_out   (cell_id[i]),
         .match    (match[i])
      );
   end

   // oldest id as it will stand after this update
   always_comb begin
      if (cell_ctl[0].load) begin
         oldest_next = page_id_ff;
      end else if (cell_ctl[0].shift) begin
         oldest_next = cell_id[1];
      end else begin
         oldest_next = cell_id[0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (update_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_active_capacity;
         end
         if (update_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture, compare result and result beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_type_ff <= req_type;
         page_id_ff  <= req_page_id;
         match_ff    <= match;
      end
      if (update_fire) begin
         hit_ff          <= hit;
         ev_valid_ff     <= evict;
         ev_id_ff        <= evict ? cell_id[0] : '0;
         oldest_valid_ff <= (count_in != '0);
         oldest_id_ff    <= (count_in != '0) ? oldest_next : '0;
         rsp_count_ff    <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_id    = ev_id_ff;
   assign rsp_oldest_valid  = oldest_valid_ff;
   assign rsp_oldest_id     = oldest_id_ff;
   assign rsp_entry_count   = rsp_count_ff;

   // checks
   `LRU_ASSERT(a_unique_match, clock, reset, (state_ff == ST_UPDATE) |-> $onehot0(match_ff), "more than one cell matched the request id")
   `LRU_ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= CNT_W'(MAX_ENTRIES)), "entry count above list depth")
   `LRU_ASSERT(a_rsp_count, clock, reset, update_fire |=> (rsp_valid && (rsp_entry_count == count_ff)), "result count differs from stored count")
   `LRU_ASSERT(a_hit_no_evict, clock, reset, rsp_valid |-> !(rsp_hit && rsp_evicted_valid), "eviction reported on a hit")
   `LRU_ASSERT(a_accept_update, clock, reset, req_fire |=> (state_ff == ST_UPDATE), "accepted beat did not enter the update cycle")
endmodule
`default_nettype wire
